// File: hdl/byte_stream_ring_fifo_unit_defines.svh
// Assertion macros used by the byte stream ring FIFO back end.
`ifndef BYTE_STREAM_RING_FIFO_UNIT_DEFINES_SVH
`define BYTE_STREAM_RING_FIFO_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define BSRF_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define BSRF_ASSERT_NEXT(lbl, trig, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (expr)) \
        else $error(msg);

`endif

// File: hdl/bsrf_pkg.sv
// Shared types and constants of the byte stream ring FIFO.
`timescale 1ns / 1ps
package bsrf_pkg;

    localparam int DEPTH_DEF    = 1024;
    localparam int MAX_PEEK_DEF = 64;

    localparam int DATA_W = 8;
    localparam int CNT_W  = 11;
    localparam int TOT_W  = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_PEEK  = 2'd1,
        OP_POP   = 2'd2,
        OP_END   = 2'd3
    } op_t;

    // One decoded command waiting in the front queue
    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] data_byte;
        logic [CNT_W-1:0]  length;
    } item_t;

    // One result transaction
    typedef struct packed {
        logic [DATA_W-1:0] read_byte;
        logic              byte_valid;
        logic              last;
        logic [CNT_W-1:0]  done_count;
        logic [CNT_W-1:0]  fill_level;
        logic [CNT_W-1:0]  space_left;
        logic              input_closed;
        logic              end_of_stream;
        logic              error_flag;
        logic [TOT_W-1:0]  total_written;
        logic [TOT_W-1:0]  total_read;
    } res_t;

endpackage

// File: hdl/bsrf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bsrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/bsrf_front.sv
// Front end: accepts input transactions, decodes them into a two-entry queue.
`timescale 1ns / 1ps
module bsrf_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_command,
    input  logic [bsrf_pkg::DATA_W-1:0] s_data_byte,
    input  logic [bsrf_pkg::CNT_W-1:0]  s_length,
    output logic                        q_valid,
    output bsrf_pkg::item_t             q_item,
    input  logic                        q_pop
);
    import bsrf_pkg::*;

    item_t      entry_reg [2];
    logic       wr_sel_reg, wr_sel_next;
    logic       rd_sel_reg, rd_sel_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    item_t      new_item;

    // every 2-bit command value is a defined operation
    always_comb begin
        new_item.op        = op_t'(s_command);
        new_item.data_byte = s_data_byte;
        new_item.length    = s_length;
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_sel_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_sel_next = push ? ~wr_sel_reg : wr_sel_reg;
        rd_sel_next = pop ? ~rd_sel_reg : rd_sel_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_sel_reg <= 1'b0;
            rd_sel_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_sel_reg <= wr_sel_next;
            rd_sel_reg <= rd_sel_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_sel_reg] <= new_item;
        end
    end

endmodule

// File: hdl/bsrf_back.sv
// Back end: stream state, ring store and the result output register.
`timescale 1ns / 1ps
module bsrf_back #(
    parameter int DEPTH    = bsrf_pkg::DEPTH_DEF,
    parameter int MAX_PEEK = bsrf_pkg::MAX_PEEK_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [bsrf_pkg::CNT_W-1:0] capacity,
    input  logic                       q_valid,
    input  bsrf_pkg::item_t            q_item,
    output logic                       q_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output bsrf_pkg::res_t             m_res
);
    import bsrf_pkg::*;
`include "byte_stream_ring_fifo_unit_defines.svh"

    localparam int AW        = $clog2(DEPTH);
    localparam int PW        = $clog2(MAX_PEEK + 1);
    localparam int DEPTH_CAP = (DEPTH > 2047) ? 2047 : DEPTH;
    localparam int SUM_W     = ((AW > CNT_W) ? AW : CNT_W) + 1;
    localparam logic [CNT_W-1:0] DEPTH_CAP_V = CNT_W'(DEPTH_CAP);
    localparam logic [CNT_W-1:0] MAX_PEEK_V  = CNT_W'(MAX_PEEK);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_PEEK = 2'b10
    } state_t;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
        return r;
    endfunction

    state_t            state_reg, state_next;
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              closed_reg, closed_next;
    logic              err_reg, err_next;
    logic [TOT_W-1:0]  wtot_reg, wtot_next;
    logic [TOT_W-1:0]  rtot_reg, rtot_next;
    logic [AW-1:0]     peek_addr_reg, peek_addr_next;
    logic [PW-1:0]     peek_idx_reg, peek_idx_next;
    logic [PW-1:0]     peek_n_reg, peek_n_next;
    logic              m_valid_reg, m_valid_next;
    res_t              m_res_reg, m_res_next;

    logic              out_free;
    logic              load;
    logic [CNT_W-1:0]  cap_eff;
    logic [CNT_W-1:0]  space_cur;
    logic [CNT_W-1:0]  min_len;
    logic [CNT_W-1:0]  peek_cnt;
    logic [SUM_W-1:0]  pop_sum;
    logic [TOT_W:0]    wsum;
    logic [TOT_W:0]    rsum;
    logic              peek_last;

    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    bsrf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (q_item.data_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign cap_eff   = (capacity > DEPTH_CAP_V) ? DEPTH_CAP_V : capacity;
    assign space_cur = (cap_eff > fill_reg) ? cap_eff - fill_reg : '0;
    assign min_len   = (q_item.length < fill_reg) ? q_item.length : fill_reg;
    assign peek_cnt  = err_reg ? '0 : ((min_len > MAX_PEEK_V) ? MAX_PEEK_V : min_len);
    assign pop_sum   = SUM_W'(rd_ptr_reg) + SUM_W'(min_len);
    assign wsum      = {1'b0, wtot_reg} + (TOT_W + 1)'(1);
    assign rsum      = {1'b0, rtot_reg} + (TOT_W + 1)'(min_len);
    assign peek_last = ((peek_idx_reg + PW'(1)) == peek_n_reg);

    always_comb begin
        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        fill_next      = fill_reg;
        closed_next    = closed_reg;
        err_next       = err_reg;
        wtot_next      = wtot_reg;
        rtot_next      = rtot_reg;
        peek_addr_next = peek_addr_reg;
        peek_idx_next  = peek_idx_reg;
        peek_n_next    = peek_n_reg;
        q_pop          = 1'b0;
        load           = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = peek_addr_reg;
        m_res_next     = m_res_reg;
        m_res_next.read_byte  = '0;
        m_res_next.byte_valid = 1'b0;
        m_res_next.last       = 1'b1;
        m_res_next.done_count = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    load  = 1'b1;
                    unique case (q_item.op)
                        OP_WRITE: begin
                            if (closed_reg || err_reg) begin
                                err_next = 1'b1;
                            end else if (space_cur != '0) begin
                                ram_we      = 1'b1;
                                wr_ptr_next = ptr_inc(wr_ptr_reg);
                                fill_next   = fill_reg + CNT_W'(1);
                                wtot_next   = wsum[TOT_W] ? '1 : wsum[TOT_W-1:0];
                                m_res_next.done_count = CNT_W'(1);
                            end
                        end
                        OP_PEEK: begin
                            if (peek_cnt != '0) begin
                                // first byte is read now, shown from ST_PEEK
                                load           = 1'b0;
                                ram_re         = 1'b1;
                                ram_raddr      = rd_ptr_reg;
                                peek_addr_next = ptr_inc(rd_ptr_reg);
                                peek_idx_next  = '0;
                                peek_n_next    = PW'(peek_cnt);
                                state_next     = ST_PEEK;
                            end
                        end
                        OP_POP: begin
                            if (!err_reg) begin
                                rd_ptr_next = (pop_sum >= SUM_W'(DEPTH)) ?
                                              AW'(pop_sum - SUM_W'(DEPTH)) : AW'(pop_sum);
                                fill_next   = fill_reg - min_len;
                                rtot_next   = rsum[TOT_W] ? '1 : rsum[TOT_W-1:0];
                                m_res_next.done_count = min_len;
                            end
                        end
                        OP_END: begin
                            closed_next = 1'b1;
                        end
                        default: begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            ST_PEEK: begin
                // read data holds in the RAM register until the output frees up
                if (out_free) begin
                    load = 1'b1;
                    m_res_next.read_byte  = ram_rdata;
                    m_res_next.byte_valid = 1'b1;
                    m_res_next.last       = peek_last;
                    m_res_next.done_count = CNT_W'(peek_n_reg);
                    if (peek_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        ram_re         = 1'b1;
                        peek_addr_next = ptr_inc(peek_addr_reg);
                        peek_idx_next  = peek_idx_reg + PW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // status always reflects the state after this operation
        m_res_next.fill_level    = fill_next;
        m_res_next.space_left    = (cap_eff > fill_next) ? cap_eff - fill_next : '0;
        m_res_next.input_closed  = closed_next;
        m_res_next.end_of_stream = closed_next && (fill_next == '0);
        m_res_next.error_flag    = err_next;
        m_res_next.total_written = wtot_next;
        m_res_next.total_read    = rtot_next;

        m_valid_next = load || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            fill_reg    <= '0;
            closed_reg  <= 1'b0;
            err_reg     <= 1'b0;
            wtot_reg    <= '0;
            rtot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            fill_reg    <= fill_next;
            closed_reg  <= closed_next;
            err_reg     <= err_next;
            wtot_reg    <= wtot_next;
            rtot_reg    <= rtot_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        peek_addr_reg <= peek_addr_next;
        peek_idx_reg  <= peek_idx_next;
        peek_n_reg    <= peek_n_next;
        if (load) begin
            m_res_reg <= m_res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    `BSRF_ASSERT_ALWAYS(a_fill_bound, fill_reg <= DEPTH_CAP_V, "fill exceeds ring size")
    `BSRF_ASSERT_ALWAYS(a_peek_idx, (state_reg != ST_PEEK) || (peek_idx_reg < peek_n_reg),
        "peek index ran past its count")
    `BSRF_ASSERT_NEXT(a_err_sticky, err_reg, err_reg, "sticky error cleared")
    `BSRF_ASSERT_NEXT(a_wtot_mono, 1'b1, wtot_reg >= $past(wtot_reg), "write total decreased")

endmodule

// File: hdl/byte_stream_ring_fifo_unit.sv
// Top level of the byte stream ring FIFO: config register, front queue, back end.
`timescale 1ns / 1ps
// Byte FIFO kept in a ring store of DEPTH bytes, capacity set by cfg_data.
// Input channel (s_*): one command per transaction - write a byte, peek,
// pop, or end input. Result channel (m_*): one transaction per write, pop
// or end input; a peek returns one transaction per byte (at most MAX_PEEK),
// or a single empty one when it yields nothing. Every result carries the
// stream status after the command. Config channel (cfg_*) is always ready
// and must only be written while the block is idle.
// With the queue empty, a result becomes valid on m_* once its input
// transaction has passed the front queue register and the back end has
// loaded the output register; the first byte of a peek also passes the
// registered store read.
// Writes, pops and end input run at one per cycle while the receiver takes
// results; a peek holds the back end until its last byte is loaded, set by
// the one read port of the ring store and its registered read.
// Reset clears pointers, fill count, flags and totals at once and sets the
// capacity to 1024; store contents are left as they are, there is no
// clearing pass. When the receiver stalls, the output register holds its
// transaction, the back end stops, and the two-entry front queue fills
// before s_ready drops.
module byte_stream_ring_fifo_unit #(
    parameter int DEPTH    = bsrf_pkg::DEPTH_DEF,
    parameter int MAX_PEEK = bsrf_pkg::MAX_PEEK_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bsrf_pkg::CNT_W-1:0]  cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_command,
    input  logic [bsrf_pkg::DATA_W-1:0] s_data_byte,
    input  logic [bsrf_pkg::CNT_W-1:0]  s_length,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bsrf_pkg::DATA_W-1:0] m_read_byte,
    output logic                        m_byte_valid,
    output logic                        m_last,
    output logic [bsrf_pkg::CNT_W-1:0]  m_done_count,
    output logic [bsrf_pkg::CNT_W-1:0]  m_fill_level,
    output logic [bsrf_pkg::CNT_W-1:0]  m_space_left,
    output logic                        m_input_closed,
    output logic                        m_end_of_stream,
    output logic                        m_error_flag,
    output logic [bsrf_pkg::TOT_W-1:0]  m_total_written,
    output logic [bsrf_pkg::TOT_W-1:0]  m_total_read
);
    import bsrf_pkg::*;

    logic [CNT_W-1:0] capacity_reg;
    logic             q_valid;
    item_t            q_item;
    logic             q_pop;
    res_t             res;

    // capacity register; the user must make writes land only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_valid) begin
            capacity_reg <= cfg_data;
        end
    end

    bsrf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_data_byte (s_data_byte),
        .s_length    (s_length),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    bsrf_back #(
        .DEPTH    (DEPTH),
        .MAX_PEEK (MAX_PEEK)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .capacity (capacity_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (res)
    );

    assign m_read_byte     = res.read_byte;
    assign m_byte_valid    = res.byte_valid;
    assign m_last          = res.last;
    assign m_done_count    = res.done_count;
    assign m_fill_level    = res.fill_level;
    assign m_space_left    = res.space_left;
    assign m_input_closed  = res.input_closed;
    assign m_end_of_stream = res.end_of_stream;
    assign m_error_flag    = res.error_flag;
    assign m_total_written = res.total_written;
    assign m_total_read    = res.total_read;

endmodule
